@@ hdl/svd_pkg.sv @@
// ----------------------------------------------------------------------------
// svd_pkg
// Shared types and constants of the path vertex decoder.
// ----------------------------------------------------------------------------
package svd_pkg;

  // Default width of the internal coordinate registers.
  localparam int unsigned CoordWidthDef = 32;

  // Width of the numeric fields on the ports.
  localparam int unsigned PortWidth = 32;

  // Token kinds.
  typedef enum logic [1:0] {
    KIND_LETTER     = 2'd0,
    KIND_NUMBER     = 2'd1,
    KIND_LETTER_NUM = 2'd2,
    KIND_END        = 2'd3
  } kind_e;

  // Command letters, ASCII.
  localparam logic [7:0] LtrMUp = 8'h4D;
  localparam logic [7:0] LtrMLo = 8'h6D;
  localparam logic [7:0] LtrLUp = 8'h4C;
  localparam logic [7:0] LtrLLo = 8'h6C;
  localparam logic [7:0] LtrVUp = 8'h56;
  localparam logic [7:0] LtrVLo = 8'h76;
  localparam logic [7:0] LtrHUp = 8'h48;
  localparam logic [7:0] LtrHLo = 8'h68;
  localparam logic [7:0] LtrZUp = 8'h5A;
  localparam logic [7:0] LtrZLo = 8'h7A;
  localparam logic [7:0] LtrAUp = 8'h41;
  localparam logic [7:0] LtrALo = 8'h61;

  // One input token word.
  typedef struct packed {
    kind_e                 kind;
    logic [7:0]            letter;
    logic [PortWidth-1:0]  value;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic [PortWidth-1:0]  vert_x;
    logic [PortWidth-1:0]  vert_y;
    logic                  path_done;
  } res_word_t;

endpackage

@@ hdl/svd_in_stage.sv @@
// ----------------------------------------------------------------------------
// svd_in_stage
// Input register of the decoder: holds one token word until the core takes it.
// ----------------------------------------------------------------------------
module svd_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  svd_pkg::in_word_t  in_word_i,
  input  logic               out_ready_i,
  output logic               adv_o,
  output svd_pkg::in_word_t  word_o
);

  logic              valid_d, valid_q;
  svd_pkg::in_word_t word_q;
  logic              accept;

  // The held word moves on whenever the result slot can take it.
  assign adv_o      = valid_q & out_ready_i;
  assign in_stall_o = valid_q & ~adv_o;
  assign accept     = in_valid_i & ~in_stall_o;
  assign word_o     = word_q;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (adv_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q <= in_word_i;
    end
  end

endmodule

@@ hdl/svd_core.sv @@
// ----------------------------------------------------------------------------
// svd_core
// Path state registers and the single-pass token decode with saturating adds.
// ----------------------------------------------------------------------------
module svd_core #(
  parameter int unsigned CoordWidth = svd_pkg::CoordWidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  svd_pkg::in_word_t  word_i,
  output logic               emit_o,
  output svd_pkg::res_word_t res_o
);

  localparam int unsigned Pw = svd_pkg::PortWidth;
  localparam logic [CoordWidth-1:0] CoordMax = {1'b0, {(CoordWidth-1){1'b1}}};
  localparam logic [CoordWidth-1:0] CoordMin = {1'b1, {(CoordWidth-1){1'b0}}};

  // Path state.
  logic [7:0]            cmd_d, cmd_q;
  logic                  rel_d, rel_q;
  logic [CoordWidth-1:0] pos_x_d, pos_x_q, pos_y_d, pos_y_q;
  logic [CoordWidth-1:0] pend_x_d, pend_x_q;
  logic                  await_d, await_q;
  logic [CoordWidth-1:0] start_x_d, start_x_q, start_y_d, start_y_q;
  logic                  have_d, have_q;

  logic [CoordWidth-1:0] val;
  logic [CoordWidth-1:0] add_x_b;
  logic [CoordWidth:0]   sum_x, sum_y;
  logic [CoordWidth-1:0] sat_x, sat_y;
  logic [CoordWidth-1:0] out_x, out_y;
  logic                  out_done;
  logic [7:0]            cmd_eff;
  logic                  rel_eff;
  logic                  proceed;
  logic                  is_alpha;
  logic                  vtx;

  // Bring the port value into the coordinate range.
  if (CoordWidth == Pw) begin : g_val_eq
    assign val = word_i.value;
  end else if (CoordWidth > Pw) begin : g_val_wide
    assign val = {{(CoordWidth-Pw){word_i.value[Pw-1]}}, word_i.value};
  end else begin : g_val_narrow
    logic fits;
    assign fits = (&word_i.value[Pw-1:CoordWidth-1]) | ~(|word_i.value[Pw-1:CoordWidth-1]);
    assign val  = fits ? word_i.value[CoordWidth-1:0]
                       : (word_i.value[Pw-1] ? CoordMin : CoordMax);
  end

  // Saturating adders: x adds the pending x while a y is awaited, else the value.
  assign add_x_b = await_q ? pend_x_q : val;
  assign sum_x   = {pos_x_q[CoordWidth-1], pos_x_q} + {add_x_b[CoordWidth-1], add_x_b};
  assign sum_y   = {pos_y_q[CoordWidth-1], pos_y_q} + {val[CoordWidth-1], val};
  assign sat_x   = (sum_x[CoordWidth] != sum_x[CoordWidth-1])
                   ? (sum_x[CoordWidth] ? CoordMin : CoordMax) : sum_x[CoordWidth-1:0];
  assign sat_y   = (sum_y[CoordWidth] != sum_y[CoordWidth-1])
                   ? (sum_y[CoordWidth] ? CoordMin : CoordMax) : sum_y[CoordWidth-1:0];

  assign is_alpha = ((word_i.letter >= svd_pkg::LtrAUp) && (word_i.letter <= svd_pkg::LtrZUp))
                  | ((word_i.letter >= svd_pkg::LtrALo) && (word_i.letter <= svd_pkg::LtrZLo));

  // Token decode.
  always_comb begin
    cmd_d     = cmd_q;
    rel_d     = rel_q;
    pos_x_d   = pos_x_q;
    pos_y_d   = pos_y_q;
    pend_x_d  = pend_x_q;
    await_d   = await_q;
    start_x_d = start_x_q;
    start_y_d = start_y_q;
    have_d    = have_q;
    emit_o    = 1'b0;
    out_x     = '0;
    out_y     = '0;
    out_done  = 1'b0;
    cmd_eff   = cmd_q;
    rel_eff   = rel_q;
    proceed   = 1'b1;
    vtx       = 1'b0;

    if (word_i.kind == svd_pkg::KIND_END) begin
      // End of path keeps the command and clears the rest.
      rel_d     = 1'b0;
      pos_x_d   = '0;
      pos_y_d   = '0;
      pend_x_d  = '0;
      await_d   = 1'b0;
      start_x_d = '0;
      start_y_d = '0;
      have_d    = 1'b0;
      emit_o    = 1'b1;
      out_done  = 1'b1;
    end else if (await_q) begin
      // A y completes the pair; anything carrying a letter drops the pending x.
      await_d  = 1'b0;
      pend_x_d = '0;
      if (word_i.kind == svd_pkg::KIND_NUMBER) begin
        pos_x_d = rel_q ? sat_x : pend_x_q;
        pos_y_d = rel_q ? sat_y : val;
        if ((cmd_q == svd_pkg::LtrMUp) || (cmd_q == svd_pkg::LtrMLo)) begin
          cmd_d = rel_q ? svd_pkg::LtrLLo : svd_pkg::LtrLUp;
        end
        vtx = 1'b1;
      end
    end else begin
      if (word_i.kind != svd_pkg::KIND_NUMBER) begin
        if (!is_alpha) begin
          proceed = 1'b0;
        end else begin
          cmd_eff = word_i.letter;
          rel_eff = (word_i.letter >= svd_pkg::LtrALo);
          cmd_d   = cmd_eff;
          rel_d   = rel_eff;
          if ((word_i.kind == svd_pkg::KIND_LETTER) && (cmd_eff != svd_pkg::LtrZUp)
              && (cmd_eff != svd_pkg::LtrZLo)) begin
            proceed = 1'b0;
          end
        end
      end
      if (proceed) begin
        if (cmd_eff inside {svd_pkg::LtrMUp, svd_pkg::LtrMLo,
                            svd_pkg::LtrLUp, svd_pkg::LtrLLo}) begin
          pend_x_d = val;
          await_d  = 1'b1;
        end else if (cmd_eff inside {svd_pkg::LtrVUp, svd_pkg::LtrVLo}) begin
          pos_y_d = rel_eff ? sat_y : val;
          vtx     = 1'b1;
        end else if (cmd_eff inside {svd_pkg::LtrHUp, svd_pkg::LtrHLo}) begin
          pos_x_d = rel_eff ? sat_x : val;
          vtx     = 1'b1;
        end else if (cmd_eff inside {svd_pkg::LtrZUp, svd_pkg::LtrZLo}) begin
          // Close repeats the first vertex and leaves the position alone.
          if (have_q) begin
            emit_o = 1'b1;
            out_x  = start_x_q;
            out_y  = start_y_q;
          end
        end
      end
    end

    // A new vertex also records the first vertex of the path.
    if (vtx) begin
      emit_o = 1'b1;
      out_x  = pos_x_d;
      out_y  = pos_y_d;
      if (!have_q) begin
        have_d    = 1'b1;
        start_x_d = pos_x_d;
        start_y_d = pos_y_d;
      end
    end
  end

  // Result fields carry the low port bits of the coordinate, sign-extended when it is narrower.
  if (CoordWidth >= Pw) begin : g_out_wide
    assign res_o.vert_x = out_x[Pw-1:0];
    assign res_o.vert_y = out_y[Pw-1:0];
  end else begin : g_out_narrow
    assign res_o.vert_x = {{(Pw-CoordWidth){out_x[CoordWidth-1]}}, out_x};
    assign res_o.vert_y = {{(Pw-CoordWidth){out_y[CoordWidth-1]}}, out_y};
  end
  assign res_o.path_done = out_done;

  // State update on every word that leaves the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q     <= '0;
      rel_q     <= 1'b0;
      pos_x_q   <= '0;
      pos_y_q   <= '0;
      pend_x_q  <= '0;
      await_q   <= 1'b0;
      start_x_q <= '0;
      start_y_q <= '0;
      have_q    <= 1'b0;
    end else if (adv_i) begin
      cmd_q     <= cmd_d;
      rel_q     <= rel_d;
      pos_x_q   <= pos_x_d;
      pos_y_q   <= pos_y_d;
      pend_x_q  <= pend_x_d;
      await_q   <= await_d;
      start_x_q <= start_x_d;
      start_y_q <= start_y_d;
      have_q    <= have_d;
    end
  end

endmodule

@@ hdl/svd_out_stage.sv @@
// ----------------------------------------------------------------------------
// svd_out_stage
// Result register of the decoder: holds one result word until it is taken.
// ----------------------------------------------------------------------------
module svd_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                emit_i,
  input  svd_pkg::res_word_t  res_i,
  output logic                out_ready_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output svd_pkg::res_word_t  res_o
);

  logic               valid_d, valid_q;
  svd_pkg::res_word_t res_q;

  // The slot is free when empty or when its word is taken this cycle.
  assign out_ready_o = ~valid_q | ~out_stall_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_comb begin
    valid_d = valid_q;
    if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
    if (adv_i) begin
      valid_d = emit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && emit_i) begin
      res_q <= res_i;
    end
  end

endmodule

@@ hdl/svg_path_vertex_decoder_top.sv @@
// ----------------------------------------------------------------------------
// svg_path_vertex_decoder_top
// Turns path tokens into polyline vertices and end-of-path markers.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one token word: kind_i,
//   letter_i and value_i. Output channel (out_valid_o / out_stall_i) carries
//   one result word: vert_x_o, vert_y_o and path_done_o. A word moves at a
//   rising edge where valid is high and stall is low.
//   A token yields zero or one result. A token held in the input register is
//   decoded there, and its result enters the result register as the token
//   leaves; the receiver takes it from there when it does not stall.
//   Throughput is one token per cycle while the receiver does not stall; the
//   path state (one pair of saturating adders feeding the position registers)
//   is registered as each token leaves the input register.
//   Reset clears both registers' valid flags and the path state, with the
//   command cleared to the zero byte. While the receiver stalls, the result
//   holds, one more token waits in the input register, and then in_stall_o
//   rises until the result is taken.
// ----------------------------------------------------------------------------
module svg_path_vertex_decoder_top #(
  parameter int unsigned CoordWidth = svd_pkg::CoordWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  letter_i,
  input  logic [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] vert_x_o,
  output logic [31:0] vert_y_o,
  output logic        path_done_o
);

  svd_pkg::in_word_t  in_word;
  svd_pkg::in_word_t  held_word;
  svd_pkg::res_word_t core_res;
  svd_pkg::res_word_t out_res;
  logic               adv;
  logic               out_ready;
  logic               emit;

  assign in_word.kind   = svd_pkg::kind_e'(kind_i);
  assign in_word.letter = letter_i;
  assign in_word.value  = value_i;

  svd_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word),
    .out_ready_i (out_ready),
    .adv_o       (adv),
    .word_o      (held_word)
  );

  svd_core #(
    .CoordWidth (CoordWidth)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .word_i (held_word),
    .emit_o (emit),
    .res_o  (core_res)
  );

  svd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .emit_i      (emit),
    .res_i       (core_res),
    .out_ready_o (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  assign vert_x_o    = out_res.vert_x;
  assign vert_y_o    = out_res.vert_y;
  assign path_done_o = out_res.path_done;

endmodule

@@ hdl/svd_checker.sv @@
// ----------------------------------------------------------------------------
// svd_checker
// Port-level checks of the path vertex decoder, bound to the top level.
// ----------------------------------------------------------------------------
module svd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] vert_x_o,
  input logic [31:0] vert_y_o,
  input logic        path_done_o
);

  // The end-of-path word carries a zero vertex.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && path_done_o) |-> ((vert_x_o == '0) && (vert_y_o == '0)))
    else $error("end-of-path word with nonzero vertex");

  // The input side only stalls behind a stalled result.
  assert property (@(posedge clk_i) in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while result slot free");

  // No result is shown while reset is held.
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

  // A stalled result word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(vert_x_o) && $stable(vert_y_o) && $stable(path_done_o)))
    else $error("stalled result word changed");

endmodule

bind svg_path_vertex_decoder_top svd_checker u_svd_checker (.*);

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the path vertex decoder. A directed token table
// covers the corner cases, then random path fragments run under bursty input
// and a shifting stall pattern on the output. Every result word is compared
// with a local decoder model, or with the result that its typed table row states.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned RandTokens = 1350;
  localparam int unsigned IdleLimit  = 5000;
  localparam int unsigned DrainWait  = 8;

  // One token of stimulus; typed rows carry their own expected result.
  typedef struct {
    svd_pkg::kind_e kind;
    logic [7:0]     letter;
    logic [31:0]    value;
    bit             typed;
    bit             t_emit;
    logic [31:0]    t_x;
    logic [31:0]    t_y;
    bit             t_done;
  } tok_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b1;
  logic        tok_valid = 1'b0;
  logic        out_stall = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [31:0] vert_x_o;
  logic [31:0] vert_y_o;
  logic        path_done_o;
  tok_row_t    cur_row = '{svd_pkg::KIND_LETTER, 8'h00, 32'h0, 1'b0, 1'b0, 32'h0, 32'h0,
                           1'b0};

  // Model state of the decoder.
  logic [7:0]  cmd_q = 8'h00;
  bit          rel_q;
  logic [31:0] pos_x, pos_y, pend_x, first_x, first_y;
  bit          await_y, have_first;

  svd_pkg::res_word_t pending_vertices[$];
  tok_row_t    plan[27];
  int          err_count = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;
  int          phase_left = 0;
  int          stall_mode = 0;
  int          stall_tick = 0;

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  svg_path_vertex_decoder_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (tok_valid),
    .in_stall_o (in_stall_o),
    .kind_i     (cur_row.kind),
    .letter_i   (cur_row.letter),
    .value_i    (cur_row.value),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .vert_x_o   (vert_x_o),
    .vert_y_o   (vert_y_o),
    .path_done_o(path_done_o)
  );

  // Signed add clamped to the 32-bit coordinate range.
  function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      return s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return s[31:0];
  endfunction

  function automatic bit is_cmd_move_line(input logic [7:0] c);
    return c == svd_pkg::LtrMUp || c == svd_pkg::LtrMLo ||
           c == svd_pkg::LtrLUp || c == svd_pkg::LtrLLo;
  endfunction

  // Appends one expected word at the back of the queue.
  task automatic expect_word(input svd_pkg::res_word_t w);
    pending_vertices.insert(pending_vertices.size(), w);
  endtask

  // Path state cleared on reset and on each end of path.
  task automatic clear_path();
    rel_q = 1'b0;
    pos_x = '0;
    pos_y = '0;
    pend_x = '0;
    await_y = 1'b0;
    first_x = '0;
    first_y = '0;
    have_first = 1'b0;
  endtask

  task automatic put_vertex(output bit emits, output svd_pkg::res_word_t r);
    if (!have_first) begin
      have_first = 1'b1;
      first_x = pos_x;
      first_y = pos_y;
    end
    emits = 1'b1;
    r = '0;
    r.vert_x = pos_x;
    r.vert_y = pos_y;
  endtask

  // Advances the model by one token and returns the result word, if any.
  task automatic decode_token(input svd_pkg::kind_e k, input logic [7:0] ltr,
                              input logic [31:0] v,
                              output bit emits, output svd_pkg::res_word_t r);
    bit go_on;
    emits = 1'b0;
    r = '0;
    go_on = 1'b1;
    if (k == svd_pkg::KIND_END) begin
      clear_path();
      emits = 1'b1;
      r.path_done = 1'b1;
    end else if (await_y) begin
      // A letter here kills the pending pair; a number completes it.
      await_y = 1'b0;
      if (k != svd_pkg::KIND_NUMBER) begin
        pend_x = '0;
      end else begin
        pos_x = rel_q ? add_sat(pos_x, pend_x) : pend_x;
        pos_y = rel_q ? add_sat(pos_y, v) : v;
        pend_x = '0;
        if (cmd_q == svd_pkg::LtrMUp || cmd_q == svd_pkg::LtrMLo) begin
          cmd_q = rel_q ? svd_pkg::LtrLLo : svd_pkg::LtrLUp;
        end
        put_vertex(emits, r);
      end
    end else begin
      if (k == svd_pkg::KIND_LETTER || k == svd_pkg::KIND_LETTER_NUM) begin
        if (!((ltr >= svd_pkg::LtrAUp && ltr <= svd_pkg::LtrAUp + 8'd25) ||
              (ltr >= svd_pkg::LtrALo && ltr <= svd_pkg::LtrALo + 8'd25))) begin
          go_on = 1'b0;
        end else begin
          cmd_q = ltr;
          rel_q = (ltr >= svd_pkg::LtrALo);
          if (k == svd_pkg::KIND_LETTER && ltr != svd_pkg::LtrZLo &&
              ltr != svd_pkg::LtrZUp) go_on = 1'b0;
        end
      end
      if (go_on) begin
        if (is_cmd_move_line(cmd_q)) begin
          pend_x = v;
          await_y = 1'b1;
        end else if (cmd_q == svd_pkg::LtrVUp || cmd_q == svd_pkg::LtrVLo) begin
          pos_y = rel_q ? add_sat(pos_y, v) : v;
          put_vertex(emits, r);
        end else if (cmd_q == svd_pkg::LtrHUp || cmd_q == svd_pkg::LtrHLo) begin
          pos_x = rel_q ? add_sat(pos_x, v) : v;
          put_vertex(emits, r);
        end else if ((cmd_q == svd_pkg::LtrZUp || cmd_q == svd_pkg::LtrZLo) &&
                     have_first) begin
          emits = 1'b1;
          r.vert_x = first_x;
          r.vert_y = first_y;
        end
      end
    end
  endtask

  // Input acceptance feeds the model; output acceptance is checked in order.
  always @(posedge clk_i) begin
    bit                 emits;
    svd_pkg::res_word_t r;
    svd_pkg::res_word_t e;
    if (rst_ni) begin
      if (tok_valid && !in_stall_o) begin
        decode_token(cur_row.kind, cur_row.letter, cur_row.value, emits, r);
        if (cur_row.typed) begin
          if (cur_row.t_emit) begin
            expect_word('{cur_row.t_x, cur_row.t_y, cur_row.t_done});
          end
        end else if (emits) begin
          expect_word(r);
        end
      end
      if (out_valid_o && !out_stall) begin
        if (pending_vertices.size() == 0) begin
          $display("%0t: unexpected word x=%h y=%h done=%b", $time,
                   vert_x_o, vert_y_o, path_done_o);
          err_count++;
        end else begin
          e = pending_vertices.pop_front();
          if (vert_x_o !== e.vert_x) begin
            $display("%0t: vert_x expected %h got %h", $time, e.vert_x, vert_x_o);
            err_count++;
          end
          if (vert_y_o !== e.vert_y) begin
            $display("%0t: vert_y expected %h got %h", $time, e.vert_y, vert_y_o);
            err_count++;
          end
          if (path_done_o !== e.path_done) begin
            $display("%0t: path_done expected %b got %b", $time, e.path_done, path_done_o);
            err_count++;
          end
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a word.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((tok_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no progress for %0d cycles", $time, IdleLimit);
        $display("svg_path_vertex_decoder_top test failed");
        $finish;
      end
    end
  end

  // Receiver stall pattern: phases of free flow, light and heavy random
  // stalls, and a periodic stall.
  always @(negedge clk_i) begin
    if (phase_left == 0) begin
      phase_left = $urandom_range(20, 200);
      stall_mode = $urandom_range(0, 3);
    end
    phase_left--;
    stall_tick++;
    case (stall_mode)
      0: out_stall = 1'b0;
      1: out_stall = ($urandom_range(0, 3) == 0);
      2: out_stall = ($urandom_range(0, 9) < 7);
      default: out_stall = ((stall_tick % 8) < 3);
    endcase
  end

  // Presents one word at the falling edge and holds it until it is taken.
  // Words go out in bursts with random gaps in between.
  task automatic send_word(input tok_row_t w);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      tok_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
                                               : $urandom_range(1, 30);
    end
    cur_row = w;
    tok_valid = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    burst_left--;
  endtask

  task automatic send_tok(input svd_pkg::kind_e k, input logic [7:0] ltr,
                          input logic [31:0] v);
    send_word('{k, ltr, v, 1'b0, 1'b0, 32'h0, 32'h0, 1'b0});
  endtask

  // Holds the input off until every expected word has come back.
  task automatic drain_results();
    tok_valid = 1'b0;
    burst_left = 0;
    while (pending_vertices.size() != 0) @(negedge clk_i);
  endtask

  // Coordinates: extremes, zero, full-range and small values.
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3, 4: return $urandom;
      default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    endcase
  endfunction

  function automatic logic [7:0] pick_cmd();
    case ($urandom_range(0, 9))
      0: return svd_pkg::LtrMUp;
      1: return svd_pkg::LtrMLo;
      2: return svd_pkg::LtrLUp;
      3: return svd_pkg::LtrLLo;
      4: return svd_pkg::LtrHUp;
      5: return svd_pkg::LtrHLo;
      6: return svd_pkg::LtrVUp;
      7: return svd_pkg::LtrVLo;
      8: return svd_pkg::LtrZUp;
      default: return svd_pkg::LtrZLo;
    endcase
  endfunction

  initial begin
    int          sent;
    int          sel;
    int          n;
    bit          drained_mid;
    logic [7:0]  c;

    clear_path();

    // Directed tokens; the typed rows state their result outright.
    plan[0]  = '{svd_pkg::KIND_END,        8'h00,  32'h0,         1, 1, 32'h0, 32'h0, 1};
    plan[1]  = '{svd_pkg::KIND_NUMBER,     8'h00,  32'h0001_0000, 1, 0, 32'h0, 32'h0, 0};
    plan[2]  = '{svd_pkg::KIND_LETTER,     8'h40,  32'h0,         1, 0, 32'h0, 32'h0, 0};
    plan[3]  = '{svd_pkg::KIND_LETTER_NUM, svd_pkg::LtrMUp, 32'h7FFF_FFFF,
                 1, 0, 32'h0, 32'h0, 0};
    plan[4]  = '{svd_pkg::KIND_NUMBER,     8'h00,  32'h8000_0000, 1, 1,
                 32'h7FFF_FFFF, 32'h8000_0000, 0};
    plan[5]  = '{svd_pkg::KIND_NUMBER,     8'h00,  32'h0000_0005, 1, 0, 32'h0, 32'h0, 0};
    plan[6]  = '{svd_pkg::KIND_LETTER_NUM, svd_pkg::LtrHLo, 32'h0002_0000,
                 1, 0, 32'h0, 32'h0, 0};
    plan[7]  = '{svd_pkg::KIND_LETTER,     svd_pkg::LtrLLo, 32'h0,
                 1, 0, 32'h0, 32'h0, 0};
    plan[8]  = '{svd_pkg::KIND_NUMBER,     8'h00,  32'h7FFF_FFFF, 1, 0, 32'h0, 32'h0, 0};
    plan[9]  = '{svd_pkg::KIND_NUMBER,     8'h00,  32'h7FFF_FFFF, 0, 0, 32'h0, 32'h0, 0};
    plan[10] = '{svd_pkg::KIND_LETTER_NUM, svd_pkg::LtrVLo, 32'h8000_0000,
                 0, 0, 32'h0, 32'h0, 0};
    plan[11] = '{svd_pkg::KIND_LETTER_NUM, svd_pkg::LtrHLo, 32'h1234_5678,
                 0, 0, 32'h0, 32'h0, 0};
    plan[12] = '{svd_pkg::KIND_LETTER_NUM, svd_pkg::LtrVUp, 32'hFFFF_0000,
                 0, 0, 32'h0, 32'h0, 0};
    plan[13] = '{svd_pkg::KIND_LETTER_NUM, svd_pkg::LtrHUp, 32'h0001_0000,
                 0, 0, 32'h0, 32'h0, 0};
    plan[14] = '{svd_pkg::KIND_LETTER,     svd_pkg::LtrZLo, 32'h0,
                 0, 0, 32'h0, 32'h0, 0};
    plan[15] = '{svd_pkg::KIND_NUMBER,     8'h00,  32'h0,         0, 0, 32'h0, 32'h0, 0};
    plan[16] = '{svd_pkg::KIND_LETTER_NUM, svd_pkg::LtrZUp, 32'h0000_0003,
                 0, 0, 32'h0, 32'h0, 0};
    plan[17] = '{svd_pkg::KIND_END,        8'h00,  32'h0,         1, 1, 32'h0, 32'h0, 1};
    plan[18] = '{svd_pkg::KIND_LETTER,     svd_pkg::LtrZUp, 32'h0,
                 1, 0, 32'h0, 32'h0, 0};
    plan[19] = '{svd_pkg::KIND_LETTER_NUM, svd_pkg::LtrMLo, 32'h0001_8000,
                 0, 0, 32'h0, 32'h0, 0};
    plan[20] = '{svd_pkg::KIND_NUMBER,     8'h00,  32'hFFFF_8000, 0, 0, 32'h0, 32'h0, 0};
    plan[21] = '{svd_pkg::KIND_NUMBER,     8'h00,  32'h0000_0001, 0, 0, 32'h0, 32'h0, 0};
    plan[22] = '{svd_pkg::KIND_NUMBER,     8'h00,  32'h0000_0002, 0, 0, 32'h0, 32'h0, 0};
    plan[23] = '{svd_pkg::KIND_LETTER,     8'hFF,  32'h0,         1, 0, 32'h0, 32'h0, 0};
    plan[24] = '{svd_pkg::KIND_LETTER_NUM, svd_pkg::LtrALo, 32'h7FFF_0000,
                 1, 0, 32'h0, 32'h0, 0};
    plan[25] = '{svd_pkg::KIND_NUMBER,     8'h00,  32'h0,         1, 0, 32'h0, 32'h0, 0};
    plan[26] = '{svd_pkg::KIND_END,        8'h00,  32'h0,         1, 1, 32'h0, 32'h0, 1};

    // Reset is asserted, then released at a falling edge.
    #1 rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (plan[i]) send_word(plan[i]);
    drain_results();

    // Random path fragments, mostly well formed.
    sent = 0;
    drained_mid = 1'b0;
    while (sent < RandTokens) begin
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        // A command with its arguments, the first one sometimes attached.
        c = pick_cmd();
        if (is_cmd_move_line(c)) n = 2 * $urandom_range(1, 3);
        else if (c == svd_pkg::LtrZUp || c == svd_pkg::LtrZLo) n = $urandom_range(0, 1);
        else n = $urandom_range(1, 3);
        if (n > 0 && $urandom_range(0, 1)) begin
          send_tok(svd_pkg::KIND_LETTER_NUM, c, rand_coord());
          n--;
        end else begin
          send_tok(svd_pkg::KIND_LETTER, c, $urandom);
        end
        sent++;
        repeat (n) begin
          send_tok(svd_pkg::KIND_NUMBER, 8'($urandom), rand_coord());
          sent++;
        end
      end else if (sel < 78) begin
        send_tok(svd_pkg::KIND_END, 8'($urandom), $urandom);
        sent++;
      end else if (sel < 88) begin
        // Bare numbers continue the current command.
        repeat ($urandom_range(1, 4)) begin
          send_tok(svd_pkg::KIND_NUMBER, 8'($urandom), rand_coord());
          sent++;
        end
      end else if (sel < 94) begin
        // A pair cut short by a letter token.
        send_tok(svd_pkg::KIND_LETTER_NUM, pick_cmd() & ~8'h1F | 8'h0C, rand_coord());
        send_tok($urandom_range(0, 1) ? svd_pkg::KIND_LETTER : svd_pkg::KIND_LETTER_NUM,
                 pick_cmd(), rand_coord());
        sent += 2;
      end else begin
        // Noise: any letter byte and any value.
        send_tok(svd_pkg::kind_e'($urandom_range(0, 2)), 8'($urandom_range(0, 255)),
                 $urandom);
        sent++;
      end
      if (!drained_mid && sent >= RandTokens / 2) begin
        drained_mid = 1'b1;
        drain_results();
      end
    end

    // Wait for the tail of the pipeline, then report.
    drain_results();
    repeat (DrainWait) @(negedge clk_i);
    if (pending_vertices.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, pending_vertices.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("svg_path_vertex_decoder_top test passed");
    end else begin
      $display("svg_path_vertex_decoder_top test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/svd_pkg.sv
hdl/svd_in_stage.sv
hdl/svd_core.sv
hdl/svd_out_stage.sv
hdl/svg_path_vertex_decoder_top.sv
hdl/svd_checker.sv
bench/tb_top.sv
